@@ design/mscs_pkg.sv @@
// ----------------------------------------------------------------------------
// mscs_pkg
// shared types and constants of the marching squares cell segment block
// ----------------------------------------------------------------------------
package mscs_pkg;

    localparam int COORD_W = 32;
    localparam int LEN_W   = 31;
    localparam int MAG_W   = 32;
    localparam int DEN_W   = 33;
    localparam int QUO_W   = 31;
    localparam int PROD_W  = MAG_W + LEN_W;

    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_LEFT   = 2'd1;
    localparam logic [1:0] EDGE_RIGHT  = 2'd2;
    localparam logic [1:0] EDGE_BOTTOM = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] fixed_coord;
        logic [COORD_W-1:0] base;
        logic               on_y;
        logic [MAG_W-1:0]   mag;
        logic [DEN_W-1:0]   den;
        logic [LEN_W-1:0]   len;
    } endpoint_t;

    typedef struct packed {
        logic      seg_valid;
        logic      saddle;
        logic [3:0] case_idx;
        endpoint_t p0;
        endpoint_t p1;
    } cell_job_t;

    typedef struct packed {
        logic               seg_valid;
        logic               saddle;
        logic [3:0]         case_idx;
        logic [COORD_W-1:0] fixed0;
        logic [COORD_W-1:0] base0;
        logic               on_y0;
        logic [COORD_W-1:0] fixed1;
        logic [COORD_W-1:0] base1;
        logic               on_y1;
    } cell_side_t;

endpackage

@@ design/mscs_front.sv @@
// ----------------------------------------------------------------------------
// mscs_front
// classifies corners, picks the crossed edges and prepares the divisions
// ----------------------------------------------------------------------------
module mscs_front
    import mscs_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        cell_x,
    input  logic [31:0]        cell_y,
    input  logic [31:0]        corner_top_left,
    input  logic [31:0]        corner_top_right,
    input  logic [31:0]        corner_bottom_right,
    input  logic [31:0]        corner_bottom_left,
    input  logic [LEN_W-1:0]   cell_width,
    input  logic [LEN_W-1:0]   cell_height,
    input  logic               fifo_full,
    output logic               push,
    output cell_job_t          job
);

    localparam int CB = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    logic             valid_reg;
    cell_job_t        job_reg;
    cell_job_t        job_next;
    logic signed [32:0] tl;
    logic signed [32:0] tr;
    logic signed [32:0] br;
    logic signed [32:0] bl;
    logic [3:0]       ci;
    endpoint_t        pt_top;
    endpoint_t        pt_left;
    endpoint_t        pt_right;
    endpoint_t        pt_bottom;
    endpoint_t        pt_none;
    logic [1:0]       e0;
    logic [1:0]       e1;
    logic             seg;
    logic             accept;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : 33'(v);
        return m[MAG_W-1:0];
    endfunction

    function automatic logic [DEN_W-1:0] den_of(input logic signed [32:0] p,
                                                 input logic signed [32:0] q);
        logic signed [33:0] d;
        logic [33:0]        m;
        d = 34'(p) - 34'(q);
        m = d[33] ? 34'(-d) : 34'(d);
        return m[DEN_W-1:0];
    endfunction

    always_comb
    begin
        tl = 33'($signed(corner_top_left[CB-1:0]));
        tr = 33'($signed(corner_top_right[CB-1:0]));
        br = 33'($signed(corner_bottom_right[CB-1:0]));
        bl = 33'($signed(corner_bottom_left[CB-1:0]));
        ci = {(bl > 0), (br > 0), (tr > 0), (tl > 0)};

        pt_top    = '{fixed_coord: cell_y, base: cell_x, on_y: 1'b0,
                      mag: mag_of(tl), den: den_of(tl, tr), len: cell_width};
        pt_left   = '{fixed_coord: cell_x, base: cell_y, on_y: 1'b1,
                      mag: mag_of(tl), den: den_of(tl, bl), len: cell_height};
        pt_right  = '{fixed_coord: cell_x + {1'b0, cell_width}, base: cell_y,
                      on_y: 1'b1, mag: mag_of(tr), den: den_of(tr, br),
                      len: cell_height};
        pt_bottom = '{fixed_coord: cell_y + {1'b0, cell_height}, base: cell_x,
                      on_y: 1'b0, mag: mag_of(bl), den: den_of(bl, br),
                      len: cell_width};
        // zero numerator over unit divisor gives all-zero endpoints
        pt_none   = '{fixed_coord: '0, base: '0, on_y: 1'b0, mag: '0,
                      den: DEN_W'(1), len: '0};

        seg = 1'b1;
        e0  = EDGE_TOP;
        e1  = EDGE_TOP;
        unique case (ci) inside
            4'd1, 4'd14:
            begin
                e0 = EDGE_TOP;
                e1 = EDGE_LEFT;
            end
            4'd2, 4'd13:
            begin
                e0 = EDGE_TOP;
                e1 = EDGE_RIGHT;
            end
            4'd4, 4'd11:
            begin
                e0 = EDGE_BOTTOM;
                e1 = EDGE_RIGHT;
            end
            4'd7, 4'd8:
            begin
                e0 = EDGE_BOTTOM;
                e1 = EDGE_LEFT;
            end
            4'd3, 4'd12:
            begin
                e0 = EDGE_LEFT;
                e1 = EDGE_RIGHT;
            end
            4'd6, 4'd9:
            begin
                e0 = EDGE_TOP;
                e1 = EDGE_BOTTOM;
            end
            default:
            begin
                seg = 1'b0;
            end
        endcase

        job_next.seg_valid = seg;
        job_next.saddle    = (ci == 4'd5) || (ci == 4'd10);
        job_next.case_idx  = ci;
        job_next.p0        = pt_none;
        job_next.p1        = pt_none;
        if (seg)
        begin
            case (e0)
                EDGE_TOP:    job_next.p0 = pt_top;
                EDGE_LEFT:   job_next.p0 = pt_left;
                EDGE_RIGHT:  job_next.p0 = pt_right;
                default:     job_next.p0 = pt_bottom;
            endcase
            case (e1)
                EDGE_TOP:    job_next.p1 = pt_top;
                EDGE_LEFT:   job_next.p1 = pt_left;
                EDGE_RIGHT:  job_next.p1 = pt_right;
                default:     job_next.p1 = pt_bottom;
            endcase
        end
    end

    assign push   = valid_reg && !fifo_full;
    assign busy   = valid_reg && fifo_full;
    assign accept = start && !busy;
    assign job    = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

@@ design/mscs_fifo.sv @@
// ----------------------------------------------------------------------------
// mscs_fifo
// two-entry queue between classification and interpolation
// ----------------------------------------------------------------------------
module mscs_fifo
    import mscs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cell_job_t push_data,
    output logic      full,
    output logic      pop,
    output cell_job_t pop_data
);

    cell_job_t  mem [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign pop      = (count_reg != 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/mscs_div.sv @@
// ----------------------------------------------------------------------------
// mscs_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module mscs_div
    import mscs_pkg::*;
(
    input  logic              clk,
    input  logic [PROD_W-1:0] num,
    input  logic [DEN_W-1:0]  den,
    output logic [QUO_W-1:0]  quo
);

    logic [DEN_W-1:0] rem_reg [0:QUO_W];
    logic [QUO_W-1:0] num_reg [0:QUO_W];
    logic [DEN_W-1:0] den_reg [0:QUO_W];
    logic [QUO_W-1:0] q_reg   [0:QUO_W];

    // quotient fits QUO_W bits, so the upper numerator part is below den
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {2'b00, num[PROD_W-2:QUO_W]};
        num_reg[0] <= num[QUO_W-1:0];
        den_reg[0] <= den;
        q_reg[0]   <= '0;
    end

    for (genvar s = 1; s <= QUO_W; s++)
    begin : g_stage
        logic [DEN_W:0] trial;
        logic           ge;

        assign trial = {rem_reg[s-1], num_reg[s-1][QUO_W-s]};
        assign ge    = (trial >= {1'b0, den_reg[s-1]});

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= ge ? DEN_W'(trial - {1'b0, den_reg[s-1]}) : trial[DEN_W-1:0];
            num_reg[s] <= num_reg[s-1];
            den_reg[s] <= den_reg[s-1];
            q_reg[s]   <= {q_reg[s-1][QUO_W-2:0], ge};
        end
    end

    assign quo = q_reg[QUO_W];

endmodule

@@ design/mscs_back.sv @@
// ----------------------------------------------------------------------------
// mscs_back
// scales, divides and offsets both endpoints of a segment
// ----------------------------------------------------------------------------
module mscs_back
    import mscs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  cell_job_t   in_job,
    output logic        done,
    output logic        segment_valid,
    output logic        saddle_flag,
    output logic [3:0]  case_index,
    output logic [31:0] start_x,
    output logic [31:0] start_y,
    output logic [31:0] end_x,
    output logic [31:0] end_y
);

    logic [PROD_W-1:0] prod0_reg;
    logic [PROD_W-1:0] prod1_reg;
    logic [DEN_W-1:0]  den0_reg;
    logic [DEN_W-1:0]  den1_reg;
    cell_side_t        side_a_reg;
    logic              va_reg;
    cell_side_t        side_reg [0:QUO_W];
    logic              v_reg    [0:QUO_W];
    logic [QUO_W-1:0]  quo0;
    logic [QUO_W-1:0]  quo1;
    cell_side_t        side_out;
    logic [31:0]       pos0;
    logic [31:0]       pos1;
    logic              done_reg;
    logic              seg_reg;
    logic              saddle_reg;
    logic [3:0]        ci_reg;
    logic [31:0]       sx_reg;
    logic [31:0]       sy_reg;
    logic [31:0]       ex_reg;
    logic [31:0]       ey_reg;

    // multiply stage
    always_ff @(posedge clk)
    begin
        prod0_reg  <= PROD_W'(in_job.p0.mag) * PROD_W'(in_job.p0.len);
        prod1_reg  <= PROD_W'(in_job.p1.mag) * PROD_W'(in_job.p1.len);
        den0_reg   <= in_job.p0.den;
        den1_reg   <= in_job.p1.den;
        side_a_reg <= '{seg_valid: in_job.seg_valid, saddle: in_job.saddle,
                        case_idx: in_job.case_idx,
                        fixed0: in_job.p0.fixed_coord, base0: in_job.p0.base,
                        on_y0: in_job.p0.on_y,
                        fixed1: in_job.p1.fixed_coord, base1: in_job.p1.base,
                        on_y1: in_job.p1.on_y};
    end

    mscs_div u_div0 (
        .clk (clk),
        .num (prod0_reg),
        .den (den0_reg),
        .quo (quo0)
    );

    mscs_div u_div1 (
        .clk (clk),
        .num (prod1_reg),
        .den (den1_reg),
        .quo (quo1)
    );

    // sideband follows the divider stages
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_a_reg;
    end

    for (genvar s = 1; s <= QUO_W; s++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            side_reg[s] <= side_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            v_reg[0] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= in_valid;
            v_reg[0] <= va_reg;
            done_reg <= v_reg[QUO_W];
        end
    end

    assign side_out = side_reg[QUO_W];
    assign pos0     = side_out.base0 + {1'b0, quo0};
    assign pos1     = side_out.base1 + {1'b0, quo1};

    always_ff @(posedge clk)
    begin
        seg_reg    <= side_out.seg_valid;
        saddle_reg <= side_out.saddle;
        ci_reg     <= side_out.case_idx;
        sx_reg     <= side_out.on_y0 ? side_out.fixed0 : pos0;
        sy_reg     <= side_out.on_y0 ? pos0 : side_out.fixed0;
        ex_reg     <= side_out.on_y1 ? side_out.fixed1 : pos1;
        ey_reg     <= side_out.on_y1 ? pos1 : side_out.fixed1;
    end

    assign done          = done_reg;
    assign segment_valid = seg_reg;
    assign saddle_flag   = saddle_reg;
    assign case_index    = ci_reg;
    assign start_x       = sx_reg;
    assign start_y       = sy_reg;
    assign end_x         = ex_reg;
    assign end_y         = ey_reg;

    // history before the first clock reads as no transfer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg == ($past(in_valid, QUO_W + 3) === 1'b1))
        else $error("result strobe does not follow queue pop");

endmodule

@@ design/marching_squares_cell_segment.sv @@
// ----------------------------------------------------------------------------
// marching_squares_cell_segment
// one grid cell in, one isoline segment with linear interpolation out
//
//   channel   handshake                           payload
//   cell in   start / busy                        cell_x .. corner_bottom_left
//   result    done, one cycle, no stall           segment_valid .. end_y
//   config    apb write, pready tied high         cell_width, cell_height
//
// one cell per clock sustained; each result passes the front register, the queue,
// the multiply stage, the two 31-stage pipelined dividers, one bit per stage,
// and the output register; rst_n clears all control; no clearing pass is needed
// busy rises only if the two-entry queue fills, which never happens as the
// back end drains one item a cycle and the receiver cannot stall
// ----------------------------------------------------------------------------
module marching_squares_cell_segment
    import mscs_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] cell_x,
    input  logic [31:0] cell_y,
    input  logic [31:0] corner_top_left,
    input  logic [31:0] corner_top_right,
    input  logic [31:0] corner_bottom_right,
    input  logic [31:0] corner_bottom_left,
    output logic        done,
    output logic        segment_valid,
    output logic        saddle_flag,
    output logic [3:0]  case_index,
    output logic [31:0] start_x,
    output logic [31:0] start_y,
    output logic [31:0] end_x,
    output logic [31:0] end_y,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [LEN_W-1:0] width_reg;
    logic [LEN_W-1:0] height_reg;
    logic             cfg_wr;
    logic             fifo_full;
    logic             push;
    logic             pop;
    cell_job_t        front_job;
    cell_job_t        queue_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {1'b0, height_reg} : {1'b0, width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= LEN_W'(65536);
            height_reg <= LEN_W'(65536);
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                height_reg <= pwdata[LEN_W-1:0];
            end
            else
            begin
                width_reg <= pwdata[LEN_W-1:0];
            end
        end
    end

    mscs_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .cell_x              (cell_x),
        .cell_y              (cell_y),
        .corner_top_left     (corner_top_left),
        .corner_top_right    (corner_top_right),
        .corner_bottom_right (corner_bottom_right),
        .corner_bottom_left  (corner_bottom_left),
        .cell_width          (width_reg),
        .cell_height         (height_reg),
        .fifo_full           (fifo_full),
        .push                (push),
        .job                 (front_job)
    );

    mscs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_job),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (queue_job)
    );

    mscs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (pop),
        .in_job        (queue_job),
        .done          (done),
        .segment_valid (segment_valid),
        .saddle_flag   (saddle_flag),
        .case_index    (case_index),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y)
    );

    a_no_seg_on_saddle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(segment_valid && saddle_flag))
        else $error("segment on saddle cell");

    a_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !segment_valid) |-> (start_x == 32'd0 && start_y == 32'd0 &&
                                      end_x == 32'd0 && end_y == 32'd0))
        else $error("endpoints not cleared without segment");

    a_valid_cases: assert property (@(posedge clk) disable iff (!rst_n)
        (done && segment_valid) |-> (case_index != 4'd0 && case_index != 4'd15 &&
                                     case_index != 4'd5 && case_index != 4'd10))
        else $error("segment on empty or saddle case");

endmodule

@@ tb/tb_marching_squares_cell_segment.sv @@
// ----------------------------------------------------------------------------
// tb_marching_squares_cell_segment
// self-checking bench for the marching squares cell segment block
//
// cells go in through start/busy, segments come back on done and are checked
// field by field against typed or predicted segments; width and height are
// written over apb between phases, with extremes, under varying sender idling
// ----------------------------------------------------------------------------
module tb_marching_squares_cell_segment;
    import mscs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] tl;
        logic [31:0] tr;
        logic [31:0] br;
        logic [31:0] bl;
    } cell_t;

    typedef struct {
        logic        valid;
        logic        saddle;
        logic [3:0]  idx;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] ex;
        logic [31:0] ey;
    } segment_t;

    typedef struct {
        cell_t    c;
        logic     typed;
        segment_t seg;
    } row_t;

    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;
    localparam logic [30:0] LEN_MAX    = 31'h7fff_ffff;
    localparam int LATENCY = 37;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] cell_x = '0;
    logic [31:0] cell_y = '0;
    logic [31:0] corner_top_left = '0;
    logic [31:0] corner_top_right = '0;
    logic [31:0] corner_bottom_right = '0;
    logic [31:0] corner_bottom_left = '0;
    logic        done;
    logic        segment_valid;
    logic        saddle_flag;
    logic [3:0]  case_index;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] end_x;
    logic [31:0] end_y;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [30:0] width_reg;
    logic [30:0] height_reg;
    segment_t    pending_segs[$];
    int          errors = 0;
    int          idle_pct = 0;
    row_t        dir_rows[$];

    marching_squares_cell_segment DUT (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic logic [31:0] edge_cross(logic [31:0] base, longint p, longint q,
                                               logic [30:0] len);
        longint unsigned den;
        longint unsigned off;
        den = magnitude(p - q);
        off = (den != 0) ? (magnitude(p) * longint'(len)) / den : 0;
        return base + off[31:0];
    endfunction

    function automatic segment_t predict_segment(cell_t c);
        segment_t    s;
        longint      tl, tr, br, bl;
        logic [31:0] px[4];
        logic [31:0] py[4];
        int          e0, e1;
        tl = longint'($signed(c.tl));
        tr = longint'($signed(c.tr));
        br = longint'($signed(c.br));
        bl = longint'($signed(c.bl));
        s.idx = {bl > 0, br > 0, tr > 0, tl > 0};
        px[EDGE_TOP] = edge_cross(c.x, tl, tr, width_reg);
        py[EDGE_TOP] = c.y;
        px[EDGE_LEFT] = c.x;
        py[EDGE_LEFT] = edge_cross(c.y, tl, bl, height_reg);
        px[EDGE_RIGHT] = c.x + {1'b0, width_reg};
        py[EDGE_RIGHT] = edge_cross(c.y, tr, br, height_reg);
        px[EDGE_BOTTOM] = edge_cross(c.x, bl, br, width_reg);
        py[EDGE_BOTTOM] = c.y + {1'b0, height_reg};
        s.valid = 1'b1;
        e0 = EDGE_TOP;
        e1 = EDGE_TOP;
        case (s.idx) inside
            4'd1, 4'd14:
            begin
                e0 = EDGE_TOP;
                e1 = EDGE_LEFT;
            end
            4'd2, 4'd13:
            begin
                e0 = EDGE_TOP;
                e1 = EDGE_RIGHT;
            end
            4'd4, 4'd11:
            begin
                e0 = EDGE_BOTTOM;
                e1 = EDGE_RIGHT;
            end
            4'd7, 4'd8:
            begin
                e0 = EDGE_BOTTOM;
                e1 = EDGE_LEFT;
            end
            4'd3, 4'd12:
            begin
                e0 = EDGE_LEFT;
                e1 = EDGE_RIGHT;
            end
            4'd6, 4'd9:
            begin
                e0 = EDGE_TOP;
                e1 = EDGE_BOTTOM;
            end
            default: s.valid = 1'b0;
        endcase
        s.saddle = (s.idx == 4'd5) || (s.idx == 4'd10);
        s.sx = s.valid ? px[e0] : '0;
        s.sy = s.valid ? py[e0] : '0;
        s.ex = s.valid ? px[e1] : '0;
        s.ey = s.valid ? py[e1] : '0;
        return s;
    endfunction

    function automatic logic [31:0] rand_corner();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 6)) - 3);
            3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic cell_t rand_cell();
        cell_t c;
        c.x = $urandom;
        c.y = $urandom;
        c.tl = rand_corner();
        c.tr = rand_corner();
        c.br = rand_corner();
        c.bl = rand_corner();
        return c;
    endfunction

    task automatic apb_write(logic [2:0] addr, logic [30:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {1'b0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        @(posedge clk);
    endtask

    task automatic drain_segments();
        while (pending_segs.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic send_cell(cell_t c, logic typed, segment_t seg);
        start <= 1'b1;
        cell_x <= c.x;
        cell_y <= c.y;
        corner_top_left <= c.tl;
        corner_top_right <= c.tr;
        corner_bottom_right <= c.br;
        corner_bottom_left <= c.bl;
        do
            @(posedge clk);
        while (busy);
        pending_segs.insert(pending_segs.size(), typed ? seg : predict_segment(c));
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        segment_t s;
        if (rst_n && done)
        begin
            if (pending_segs.size() == 0)
            begin
                errors++;
                $display("%0t unexpected transfer expected none actual case %0d",
                         $time, case_index);
            end
            else
            begin
                s = pending_segs.pop_front();
                check_field("segment_valid", s.valid, segment_valid);
                check_field("saddle_flag", s.saddle, saddle_flag);
                check_field("case_index", s.idx, case_index);
                check_field("start_x", s.sx, start_x);
                check_field("start_y", s.sy, start_y);
                check_field("end_x", s.ex, end_x);
                check_field("end_y", s.ey, end_y);
            end
        end
    end

    function automatic void add_row(cell_t c, logic typed, segment_t seg);
        row_t r;
        r.c = c;
        r.typed = typed;
        r.seg = seg;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    initial
    begin
        cell_t    c;
        segment_t z;
        logic [30:0] wv, hv;
        int       n;

        z = '{default: '0};
        width_reg = 31'd65536;
        height_reg = 31'd65536;

        // no crossing, all corners zero or all positive
        c = '{x: 32'h7fff_ffff, y: 32'h8000_0000, tl: 0, tr: 0, br: 0, bl: 0};
        add_row(c, 1'b1, z);
        c = '{x: 0, y: 0, tl: 32'h7fff_ffff, tr: 1, br: 32'h7fff_ffff, bl: 1};
        z.idx = 4'd15;
        add_row(c, 1'b1, z);
        // saddles
        c = '{x: 5, y: 7, tl: 1, tr: 0, br: 1, bl: 32'h8000_0000};
        z.idx = 4'd5;
        z.saddle = 1'b1;
        add_row(c, 1'b1, z);
        c = '{x: 5, y: 7, tl: 32'hffff_ffff, tr: 32'h7fff_ffff, br: 0, bl: 3};
        z.idx = 4'd10;
        add_row(c, 1'b1, z);
        // every crossing case with extreme corners and wrapping coordinates
        for (int ci = 1; ci < 15; ci++)
        begin
            c.x = (ci % 2) ? 32'h7fff_ffff : 32'h8000_0000;
            c.y = (ci % 3) ? 32'hffff_ffff : 32'h0;
            c.tl = ci[0] ? 32'h7fff_ffff : 32'h8000_0000;
            c.tr = ci[1] ? 32'h0000_0001 : 32'h0;
            c.br = ci[2] ? 32'h7fff_ffff : 32'hffff_ffff;
            c.bl = ci[3] ? 32'h0001_0000 : 32'h8000_0000;
            add_row(c, 1'b0, z);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 24;
        foreach (dir_rows[i])
            send_cell(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].seg);
        start <= 1'b0;

        for (int ph = 0; ph < 6; ph++)
        begin
            drain_segments();
            case (ph)
                0:
                begin
                    wv = 31'd1;
                    hv = 31'd1;
                end
                1:
                begin
                    wv = LEN_MAX;
                    hv = LEN_MAX;
                end
                2:
                begin
                    wv = 31'd1;
                    hv = LEN_MAX;
                end
                3:
                begin
                    wv = LEN_MAX;
                    hv = 31'd1;
                end
                4:
                begin
                    wv = 31'd65536;
                    hv = 31'd65536;
                end
                default:
                begin
                    wv = 31'($urandom_range(1, 32'h7fff_ffff));
                    hv = 31'($urandom_range(1, 32'h7fff_ffff));
                end
            endcase
            apb_write(ADDR_WIDTH, wv);
            apb_write(ADDR_HEIGHT, hv);
            idle_pct = (ph % 3 == 0) ? 24 : (ph % 3 == 1) ? 72 : 0;
            n = (ph % 3 == 2) ? 56 : 80;
            for (int k = 0; k < n; k++)
            begin
                send_cell(rand_cell(), 1'b0, z);
                if (k == n / 2 && ph == 1)
                begin
                    start <= 1'b0;
                    drain_segments();
                end
            end
            start <= 1'b0;
        end

        drain_segments();
        repeat (LATENCY + 3) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
